### rtl/mbsp_pkg.sv
package mbsp_pkg;

  // Status byte boundaries
  localparam logic [7:0] RT_MIN        = 8'hF8;
  localparam logic [7:0] SYS_MIN       = 8'hF0;
  localparam logic [7:0] STATUS_MIN    = 8'h80;
  localparam logic [7:0] ONE_PARAM_MIN = 8'hC0;
  localparam logic [7:0] ONE_PARAM_MAX = 8'hDF;

  // System common codes
  localparam logic [7:0] SYX_START     = 8'hF0;
  localparam logic [7:0] SC_MTC        = 8'hF1;
  localparam logic [7:0] SC_SONG_POS   = 8'hF2;
  localparam logic [7:0] SC_SONG_SEL   = 8'hF3;
  localparam logic [7:0] SC_TUNE_REQ   = 8'hF6;
  localparam logic [7:0] SYX_END       = 8'hF7;

  // Parser phase codes
  localparam logic [2:0] PH_UNKNOWN = 3'd0;
  localparam logic [2:0] PH_ONE     = 3'd1;
  localparam logic [2:0] PH_TWO_A   = 3'd2;
  localparam logic [2:0] PH_TWO_B   = 3'd3;
  localparam logic [2:0] PH_SYX0    = 3'd4;
  localparam logic [2:0] PH_SYX1    = 3'd5;
  localparam logic [2:0] PH_SYX2    = 3'd6;

  // Register indexes (paddr[2])
  localparam logic REG_CHAN_OVR_EN = 1'b0;
  localparam logic REG_FORCED_CHAN = 1'b1;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  typedef struct packed {
    logic       ovr_en;
    logic [3:0] forced_chan;
  } cfg_t;

  typedef struct packed {
    logic [1:0] length;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } pkt_t;

endpackage

### rtl/midi_byte_stream_packetizer_unit.sv
// MIDI byte packetizer: takes one raw MIDI byte per beat on in_ and emits packets
// of one to three bytes plus a length on out_. It takes one byte per cycle while
// the result register is empty or drained by out_tready. A byte that produces a
// packet passes the input register, then the result register, before out_tvalid
// rises. The parser state advances when a byte leaves the input register, which
// it does whenever the result register is empty or being drained, so in_tready
// follows out_tready through that one stage. Configuration (channel override) is to
// be written by the user over the APB port only while the stream is idle; the
// block itself does not enforce it.
module midi_byte_stream_packetizer_unit
  import mbsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] midi_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] pkt_byte0, [15:8] pkt_byte1,
                                  // [23:16] pkt_byte2, [25:24] pkt_length
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t       cfg;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_free;
  logic       step;
  logic       emit;
  pkt_t       pkt_nxt;
  pkt_t       pkt_q;

  mbsp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // advance the held byte into the parser when the result slot can take it
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  mbsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .midi_byte (in_byte_r),
    .cfg       (cfg),
    .emit      (emit),
    .pkt       (pkt_nxt)
  );

  mbsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && emit),
    .pkt_in    (pkt_nxt),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .pkt_out   (pkt_q)
  );

  assign out_tdata = {6'd0, pkt_q.length, pkt_q.byte2, pkt_q.byte1, pkt_q.byte0};

  a_realtime_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_byte_r >= RT_MIN) |=> (out_tvalid && out_tdata[7:0] == $past(in_byte_r)))
    else $error("realtime byte not forwarded");

  a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !step)
    else $error("parser advanced while result slot blocked");

endmodule

### rtl/mbsp_cfg_regs.sv
module mbsp_cfg_regs
  import mbsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  logic       ovr_en_r;
  logic [3:0] fchan_r;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovr_en_r <= 1'b0;
      fchan_r  <= 4'd0;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_CHAN_OVR_EN) begin
        ovr_en_r <= cfg_pwdata[0];
      end else begin
        fchan_r <= cfg_pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_FORCED_CHAN) begin
      cfg_prdata = {28'd0, fchan_r};
    end else begin
      cfg_prdata = {31'd0, ovr_en_r};
    end
  end

  assign cfg.ovr_en      = ovr_en_r;
  assign cfg.forced_chan = fchan_r;

endmodule

### rtl/mbsp_parser.sv
module mbsp_parser
  import mbsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] midi_byte,
  input  cfg_t       cfg,
  output logic       emit,
  output pkt_t       pkt
);

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] held_first_r, held_first_nxt;
  logic [7:0] held_second_r, held_second_nxt;
  logic [7:0] chan_status;

  assign chan_status = cfg.ovr_en ? {midi_byte[7:4], cfg.forced_chan} : midi_byte;

  always_comb begin
    phase_nxt       = phase_r;
    held_first_nxt  = held_first_r;
    held_second_nxt = held_second_r;
    emit            = 1'b0;
    pkt             = '0;
    if (midi_byte >= RT_MIN) begin
      // realtime passes through, parser untouched
      emit       = 1'b1;
      pkt.byte0  = midi_byte;
      pkt.length = LEN_ONE;
    end else if (midi_byte >= SYS_MIN) begin
      case (midi_byte)
        SYX_START: begin
          held_first_nxt = midi_byte;
          phase_nxt      = PH_SYX1;
        end
        SC_MTC, SC_SONG_SEL: begin
          held_first_nxt = midi_byte;
          phase_nxt      = PH_ONE;
        end
        SC_SONG_POS: begin
          held_first_nxt = midi_byte;
          phase_nxt      = PH_TWO_A;
        end
        SC_TUNE_REQ: begin
          phase_nxt  = PH_UNKNOWN;
          emit       = 1'b1;
          pkt.byte0  = midi_byte;
          pkt.length = LEN_ONE;
        end
        SYX_END: begin
          phase_nxt = PH_UNKNOWN;
          case (phase_r)
            PH_SYX0: begin
              emit       = 1'b1;
              pkt.byte0  = SYX_END;
              pkt.length = LEN_ONE;
            end
            PH_SYX1: begin
              emit       = 1'b1;
              pkt.byte0  = held_first_r;
              pkt.byte1  = SYX_END;
              pkt.length = LEN_TWO;
            end
            PH_SYX2: begin
              emit       = 1'b1;
              pkt.byte0  = held_first_r;
              pkt.byte1  = held_second_r;
              pkt.byte2  = SYX_END;
              pkt.length = LEN_THREE;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
        default: begin
          phase_nxt = PH_UNKNOWN;
        end
      endcase
    end else if (midi_byte >= STATUS_MIN) begin
      held_first_nxt = chan_status;
      phase_nxt = (midi_byte >= ONE_PARAM_MIN && midi_byte <= ONE_PARAM_MAX) ?
                  PH_ONE : PH_TWO_A;
    end else begin
      case (phase_r)
        PH_ONE: begin
          // system common drops back; channel messages keep running status
          if (held_first_r >= SYS_MIN) begin
            phase_nxt = PH_UNKNOWN;
          end
          emit       = 1'b1;
          pkt.byte0  = held_first_r;
          pkt.byte1  = midi_byte;
          pkt.length = LEN_TWO;
        end
        PH_TWO_A: begin
          held_second_nxt = midi_byte;
          phase_nxt       = PH_TWO_B;
        end
        PH_TWO_B: begin
          phase_nxt  = (held_first_r < SYS_MIN) ? PH_TWO_A : PH_UNKNOWN;
          emit       = 1'b1;
          pkt.byte0  = held_first_r;
          pkt.byte1  = held_second_r;
          pkt.byte2  = midi_byte;
          pkt.length = LEN_THREE;
        end
        PH_SYX0: begin
          held_first_nxt = midi_byte;
          phase_nxt      = PH_SYX1;
        end
        PH_SYX1: begin
          held_second_nxt = midi_byte;
          phase_nxt       = PH_SYX2;
        end
        PH_SYX2: begin
          phase_nxt  = PH_SYX0;
          emit       = 1'b1;
          pkt.byte0  = held_first_r;
          pkt.byte1  = held_second_r;
          pkt.byte2  = midi_byte;
          pkt.length = LEN_THREE;
        end
        default: begin
          // stray data byte: drop
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_UNKNOWN;
      held_first_r  <= 8'd0;
      held_second_r <= 8'd0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      held_first_r  <= held_first_nxt;
      held_second_r <= held_second_nxt;
    end
  end

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 3'd7)
    else $error("parser phase left the legal set");

  a_sysex_full_holds_f0_or_data: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SYX2) |-> (held_second_r < STATUS_MIN))
    else $error("sysex held byte is a status byte");

endmodule

### rtl/mbsp_out_stage.sv
module mbsp_out_stage
  import mbsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  pkt_t pkt_in,
  output logic free,
  output logic out_valid,
  input  logic out_ready,
  output pkt_t pkt_out
);

  logic valid_r;
  pkt_t pkt_r;

  // slot is free when empty or its beat leaves this cycle
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign pkt_out   = pkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      pkt_r <= pkt_in;
    end
  end

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (pkt_r.length != 2'd0))
    else $error("packet with zero length");

  a_len_one_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && pkt_r.length == LEN_ONE) |-> (pkt_r.byte1 == 8'd0 && pkt_r.byte2 == 8'd0))
    else $error("unused packet bytes not zero");

endmodule
